/* rtl/core/pfd_pkg.sv */
// Shared constants, types and state encodings for the polar FM discriminator.
package pfd_pkg;

	// Field widths of the sample and result channels.
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 16;
	localparam int MAG_W    = 16;

	// Length of the sample line and width of the fill counter.
	localparam int DELAY  = 16;
	localparam int FILL_W = $clog2(DELAY + 1);

	// Fixed-point phase arithmetic: angles as fractions of pi in Q0.60.
	localparam int FRAC_BITS  = 60;
	localparam int QW         = FRAC_BITS;
	localparam int GW         = FRAC_BITS + 1;
	localparam int TURN_SHIFT = FRAC_BITS - (PHASE_W - 1);

	// Divider and series sizing.
	localparam int DIV_STEPS    = 4;
	localparam int QDIV_CYCLES  = FRAC_BITS / DIV_STEPS;
	localparam int TDIV_CYCLES  = QW / DIV_STEPS;
	localparam int CNT_W        = $clog2(QDIV_CYCLES + 1);
	localparam int SERIES_TERMS = 40;
	localparam int K_W          = $clog2(SERIES_TERMS);
	localparam int DIVISOR_W    = K_W + 1;
	localparam int DEN_W        = SAMPLE_W + 1;

	// Fold threshold: fold when min/max exceeds 29/70.
	localparam int FOLD_NUM = 70;
	localparam int FOLD_DEN = 29;
	localparam int FOLD_W   = SAMPLE_W + 7;

	// Multiplier split into 32-bit halves.
	localparam int HALF_W = 32;
	localparam int ACC_W  = 2 * QW;

	// Magnitude square root sizing.
	localparam int SQ_W       = 2 * SAMPLE_W - 1;
	localparam int SUM_W      = 2 * SAMPLE_W;
	localparam int ROOT_STEPS = SAMPLE_W;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

	// Q0.60 constants.
	localparam logic [QW-1:0] INV_PI_Q = 60'd366986312910250153;
	localparam logic [GW-1:0] Q_ONE     = GW'(1) << FRAC_BITS;
	localparam logic [GW-1:0] Q_HALF    = GW'(1) << (FRAC_BITS - 1);
	localparam logic [GW-1:0] Q_QUARTER = GW'(1) << (FRAC_BITS - 2);

	// One entry of the sample line.
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [MAG_W-1:0]   magnitude;
	} line_entry_t;

	// Request to the shared fractional multiplier.
	typedef struct packed {
		logic          start;
		logic [QW-1:0] a;
		logic [QW-1:0] b;
	} mul_req_t;

	// Phase unit sequencer.
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SETUP,
		PH_QDIV,
		PH_SQUARE,
		PH_TDIV,
		PH_TACC,
		PH_TMUL,
		PH_ATAN,
		PH_SCALE,
		PH_UNFOLD_FOLD,
		PH_UNFOLD_SWAP,
		PH_UNFOLD_SIDE,
		PH_FINISH
	} ph_state_t;

	// Magnitude unit sequencer.
	typedef enum logic [1:0] {
		MG_IDLE,
		MG_SQUARE,
		MG_SUM,
		MG_ROOT
	} mg_state_t;

	// Top-level control.
	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_WORK,
		TOP_COMMIT
	} top_state_t;

endpackage

/* rtl/core/pfd_line_cell.sv */
// One cell of the sample line: holds a phase and a magnitude and passes them on.
module pfd_line_cell
	import pfd_pkg::*;
(
	input  logic        clk,
	input  logic        shift,
	input  line_entry_t d,
	output line_entry_t q
);

	line_entry_t entry_q;

	// Take the neighbor's entry whenever the line advances.
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

/* rtl/core/pfd_qmul.sv */
// Multi-cycle Q0.60 multiplier: (a * b) >> 60 from four 32x32 partial products.
module pfd_qmul
	import pfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  mul_req_t      req,
	output logic          done,
	output logic [QW-1:0] product
);

	logic [QW-1:0]       a_q;
	logic [QW-1:0]       b_q;
	logic [ACC_W-1:0]    acc_q;
	logic [2*HALF_W-1:0] pp_q;
	logic [1:0]          pp_step_q;
	logic [2:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [HALF_W-1:0]   a_sel;
	logic [HALF_W-1:0]   b_sel;
	logic [6:0]          pp_shift;

	// Step bit 1 picks the high half of a, step bit 0 the high half of b.
	assign a_sel = cnt_q[1] ? HALF_W'(a_q[QW-1:HALF_W]) : a_q[HALF_W-1:0];
	assign b_sel = cnt_q[0] ? HALF_W'(b_q[QW-1:HALF_W]) : b_q[HALF_W-1:0];

	// Weight of a partial product is 32 times the number of high halves in it.
	assign pp_shift = {pp_step_q[1] & pp_step_q[0], pp_step_q[1] ^ pp_step_q[0], 5'b0};

	// Sequencing of the four products and the final accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial product register, then accumulate in the cycle after.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q      <= a_sel * b_sel;
				pp_step_q <= cnt_q[1:0];
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + (ACC_W'(pp_q) << pp_shift);
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q[ACC_W-1:FRAC_BITS];

endmodule

/* rtl/core/pfd_mag_unit.sv */
// Magnitude unit: squares, sum and a one-bit-per-cycle integer square root.
module pfd_mag_unit
	import pfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SAMPLE_W-1:0] i_sample,
	input  logic signed [SAMPLE_W-1:0] q_sample,
	output logic                       done,
	output logic [MAG_W-1:0]           magnitude
);

	mg_state_t               state_q;
	mg_state_t               state_d;
	logic                    done_q;
	logic                    done_d;
	logic signed [SAMPLE_W-1:0] i_q;
	logic signed [SAMPLE_W-1:0] q_q;
	logic signed [SUM_W-1:0] prod_i;
	logic signed [SUM_W-1:0] prod_q;
	logic [SQ_W-1:0]         sq_i_q;
	logic [SQ_W-1:0]         sq_q_q;
	logic [SUM_W-1:0]        s_q;
	logic [SUM_W-1:0]        root_q;
	logic [SUM_W-2:0]        bit_q;
	logic [SUM_W-1:0]        trial;
	logic [ROOT_CNT_W-1:0]   cnt_q;

	assign prod_i = i_q * i_q;
	assign prod_q = q_q * q_q;
	assign trial  = root_q + SUM_W'(bit_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MG_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// Next state and completion.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			MG_IDLE: begin
				if (start) begin
					state_d = MG_SQUARE;
				end
			end
			MG_SQUARE: state_d = MG_SUM;
			MG_SUM:    state_d = MG_ROOT;
			MG_ROOT: begin
				if (cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
					state_d = MG_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = MG_IDLE;
		endcase
	end

	// Datapath: square, add, then one root bit per cycle from the top.
	always_ff @(posedge clk) begin
		unique case (state_q)
			MG_IDLE: begin
				if (start) begin
					i_q <= i_sample;
					q_q <= q_sample;
				end
			end
			MG_SQUARE: begin
				sq_i_q <= prod_i[SQ_W-1:0];
				sq_q_q <= prod_q[SQ_W-1:0];
			end
			MG_SUM: begin
				s_q    <= SUM_W'(sq_i_q) + SUM_W'(sq_q_q);
				root_q <= '0;
				bit_q  <= (SUM_W - 1)'(1) << (SUM_W - 2);
				cnt_q  <= '0;
			end
			MG_ROOT: begin
				if (s_q >= trial) begin
					s_q    <= s_q - trial;
					root_q <= (root_q >> 1) + SUM_W'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + ROOT_CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign magnitude = root_q[MAG_W-1:0];

endmodule

/* rtl/core/pfd_phase_unit.sv */
// Phase unit: folded arctangent series in Q0.60, scaled to a 16-bit turn fraction.
module pfd_phase_unit
	import pfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SAMPLE_W-1:0] i_sample,
	input  logic signed [SAMPLE_W-1:0] q_sample,
	output logic                       done,
	output logic [PHASE_W-1:0]         phase
);

	ph_state_t              state_q;
	ph_state_t              state_d;
	logic                   mul_go;
	logic                   mul_start_q;
	logic                   done_q;
	logic                   done_d;
	mul_req_t               mul_req;
	logic                   mul_done;
	logic [QW-1:0]          mul_product;

	logic                   i_neg_q;
	logic                   q_neg_q;
	logic                   swapped_q;
	logic                   folded_q;
	logic [SAMPLE_W-1:0]    mx_q;
	logic [SAMPLE_W-1:0]    mn_q;
	logic [DEN_W-1:0]       den_q;
	logic [DEN_W-1:0]       rem_q;
	logic [QW-1:0]          u_q;
	logic [QW-1:0]          u2_q;
	logic [QW-1:0]          term_q;
	logic [QW-1:0]          pos_q;
	logic [QW-1:0]          neg_q;
	logic [QW-1:0]          dv_q;
	logic [DIVISOR_W-1:0]   drem_q;
	logic [K_W-1:0]         k_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [GW-1:0]          g_q;
	logic [PHASE_W-1:0]     phase_q;

	logic [SAMPLE_W-1:0]    ax;
	logic [SAMPLE_W-1:0]    ay;
	logic                   fold;
	logic [PHASE_W-1:0]     turn;
	logic [DIVISOR_W-1:0]   divisor;

	logic [DEN_W-1:0]       qd_rem;
	logic [QW-1:0]          qd_quo;
	logic [DEN_W:0]         qd_trial;
	logic [DIVISOR_W-1:0]   td_rem;
	logic [QW-1:0]          td_dv;
	logic [DIVISOR_W:0]     td_trial;

	// Absolute values of the incoming components.
	assign ax = i_sample[SAMPLE_W-1] ? (~i_sample + SAMPLE_W'(1)) : i_sample;
	assign ay = q_sample[SAMPLE_W-1] ? (~q_sample + SAMPLE_W'(1)) : q_sample;

	// Ratios above 29/70 are folded around pi/4.
	assign fold = (FOLD_W'(mn_q) * FOLD_W'(FOLD_NUM)) > (FOLD_W'(mx_q) * FOLD_W'(FOLD_DEN));

	assign divisor = {k_q, 1'b1};
	assign turn    = g_q[TURN_SHIFT +: PHASE_W];

	// Fraction divider: four restoring steps per cycle.
	always_comb begin
		qd_rem = rem_q;
		qd_quo = u_q;
		for (int s = 0; s < DIV_STEPS; s++) begin
			qd_trial = {qd_rem, 1'b0};
			qd_quo   = {qd_quo[QW-2:0], 1'b0};
			if (qd_trial >= {1'b0, den_q}) begin
				qd_trial  = qd_trial - {1'b0, den_q};
				qd_quo[0] = 1'b1;
			end
			qd_rem = qd_trial[DEN_W-1:0];
		end
	end

	// Series term divider by the odd number 2k+1: four steps per cycle.
	always_comb begin
		td_rem = drem_q;
		td_dv  = dv_q;
		for (int s = 0; s < DIV_STEPS; s++) begin
			td_trial = {td_rem, td_dv[QW-1]};
			td_dv    = {td_dv[QW-2:0], 1'b0};
			if (td_trial >= {1'b0, divisor}) begin
				td_trial = td_trial - {1'b0, divisor};
				td_dv[0] = 1'b1;
			end
			td_rem = td_trial[DIVISOR_W-1:0];
		end
	end

	// Shared multiplier operands follow the waiting state.
	always_comb begin
		mul_req.start = mul_start_q;
		mul_req.a     = term_q;
		mul_req.b     = u2_q;
		if (state_q == PH_SQUARE) begin
			mul_req.a = u_q;
			mul_req.b = u_q;
		end else if (state_q == PH_SCALE) begin
			mul_req.a = g_q[QW-1:0];
			mul_req.b = INV_PI_Q;
		end
	end

	pfd_qmul u_qmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_product)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PH_IDLE;
			mul_start_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			mul_start_q <= mul_go;
			done_q      <= done_d;
		end
	end

	// Next state, multiplier launch and completion.
	always_comb begin
		state_d = state_q;
		mul_go  = 1'b0;
		done_d  = 1'b0;
		unique case (state_q)
			PH_IDLE: begin
				if (start) begin
					state_d = PH_SETUP;
				end
			end
			PH_SETUP: state_d = (mx_q == '0) ? PH_FINISH : PH_QDIV;
			PH_QDIV: begin
				if (cnt_q == CNT_W'(QDIV_CYCLES - 1)) begin
					state_d = PH_SQUARE;
					mul_go  = 1'b1;
				end
			end
			PH_SQUARE: begin
				if (mul_done) begin
					state_d = PH_TDIV;
				end
			end
			PH_TDIV: begin
				if (cnt_q == CNT_W'(TDIV_CYCLES - 1)) begin
					state_d = PH_TACC;
				end
			end
			PH_TACC: begin
				if (k_q == K_W'(SERIES_TERMS - 1)) begin
					state_d = PH_ATAN;
				end else begin
					state_d = PH_TMUL;
					mul_go  = 1'b1;
				end
			end
			PH_TMUL: begin
				if (mul_done) begin
					state_d = PH_TDIV;
				end
			end
			PH_ATAN: begin
				state_d = PH_SCALE;
				mul_go  = 1'b1;
			end
			PH_SCALE: begin
				if (mul_done) begin
					state_d = PH_UNFOLD_FOLD;
				end
			end
			PH_UNFOLD_FOLD: state_d = PH_UNFOLD_SWAP;
			PH_UNFOLD_SWAP: state_d = PH_UNFOLD_SIDE;
			PH_UNFOLD_SIDE: state_d = PH_FINISH;
			PH_FINISH: begin
				state_d = PH_IDLE;
				done_d  = 1'b1;
			end
			default: state_d = PH_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			PH_IDLE: begin
				if (start) begin
					i_neg_q   <= i_sample[SAMPLE_W-1];
					q_neg_q   <= q_sample[SAMPLE_W-1];
					swapped_q <= ay > ax;
					mx_q      <= (ay > ax) ? ay : ax;
					mn_q      <= (ay > ax) ? ax : ay;
				end
			end
			PH_SETUP: begin
				folded_q <= fold;
				rem_q    <= fold ? DEN_W'(mx_q - mn_q) : DEN_W'(mn_q);
				den_q    <= fold ? (DEN_W'(mx_q) + DEN_W'(mn_q)) : DEN_W'(mx_q);
				u_q      <= '0;
				cnt_q    <= '0;
				g_q      <= '0;
			end
			PH_QDIV: begin
				rem_q <= qd_rem;
				u_q   <= qd_quo;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			PH_SQUARE: begin
				if (mul_done) begin
					u2_q   <= mul_product;
					term_q <= u_q;
					dv_q   <= u_q;
					drem_q <= '0;
					cnt_q  <= '0;
					k_q    <= '0;
					pos_q  <= '0;
					neg_q  <= '0;
				end
			end
			PH_TDIV: begin
				dv_q   <= td_dv;
				drem_q <= td_rem;
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			PH_TACC: begin
				// Odd terms of the series subtract, even terms add.
				if (k_q[0]) begin
					neg_q <= neg_q + dv_q;
				end else begin
					pos_q <= pos_q + dv_q;
				end
			end
			PH_TMUL: begin
				if (mul_done) begin
					term_q <= mul_product;
					dv_q   <= mul_product;
					drem_q <= '0;
					cnt_q  <= '0;
					k_q    <= k_q + K_W'(1);
				end
			end
			PH_ATAN: g_q <= {1'b0, pos_q - neg_q};
			PH_SCALE: begin
				if (mul_done) begin
					g_q <= {1'b0, mul_product};
				end
			end
			PH_UNFOLD_FOLD: begin
				if (folded_q) begin
					g_q <= Q_QUARTER - g_q;
				end
			end
			PH_UNFOLD_SWAP: begin
				if (swapped_q) begin
					g_q <= Q_HALF - g_q;
				end
			end
			PH_UNFOLD_SIDE: begin
				if (i_neg_q) begin
					g_q <= Q_ONE - g_q;
				end
			end
			PH_FINISH: phase_q <= q_neg_q ? (~turn + PHASE_W'(1)) : turn;
			default: ;
		endcase
	end

	assign done  = done_q;
	assign phase = phase_q;

endmodule

/* rtl/core/polar_fm_discriminator.sv */
// Top level of the polar FM discriminator: units, sample line and output register.
//
//   Channel   Signals                          Direction  Contents
//   in        in_valid, in_ready               sink       i_sample, q_sample
//   out       out_valid, out_ready             source     freq_value, magnitude_value
//
// An item's time is set by the 40-term arctangent series, which runs
// on one four-bit-per-cycle divider and one shared multi-cycle 60-bit multiplier;
// the zero vector skips the series. Magnitude runs alongside the phase unit.
// Reset clears the control state and the fill count; line contents are not read
// until the line has filled. A stalled output holds its result while the next item
// is taken and worked on; only its commit into the output register waits.
module polar_fm_discriminator
	import pfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] i_sample,
	input  logic signed [SAMPLE_W-1:0] q_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [PHASE_W-1:0]  freq_value,
	output logic [MAG_W-1:0]           magnitude_value
);

	top_state_t         top_state_q;
	top_state_t         top_state_d;
	logic               in_fire;
	logic               commit;
	logic               ph_done;
	logic [PHASE_W-1:0] ph_value;
	logic               mg_done;
	logic [MAG_W-1:0]   mg_value;
	logic               ph_seen_q;
	logic               mg_seen_q;
	logic [FILL_W-1:0]  fill_q;
	logic               line_full;
	logic               out_free;
	logic               out_valid_q;
	logic [PHASE_W-1:0] freq_q;
	logic [MAG_W-1:0]   mag_q;
	line_entry_t        new_entry;
	line_entry_t        cell_in  [DELAY];
	line_entry_t        cell_out [DELAY];
	logic [PHASE_W-1:0] next_phase;

	assign in_fire   = in_valid && in_ready;
	assign line_full = (fill_q == FILL_W'(DELAY));
	assign out_free  = !out_valid_q || out_ready;

	pfd_phase_unit u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.i_sample (i_sample),
		.q_sample (q_sample),
		.done     (ph_done),
		.phase    (ph_value)
	);

	pfd_mag_unit u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire),
		.i_sample  (i_sample),
		.q_sample  (q_sample),
		.done      (mg_done),
		.magnitude (mg_value)
	);

	// Control state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_state_q <= TOP_IDLE;
		end else begin
			top_state_q <= top_state_d;
		end
	end

	// Accept, wait for both units, then commit into the line and, once it is full, the output.
	always_comb begin
		top_state_d = top_state_q;
		in_ready    = 1'b0;
		commit      = 1'b0;
		unique case (top_state_q)
			TOP_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					top_state_d = TOP_WORK;
				end
			end
			TOP_WORK: begin
				if (ph_seen_q && mg_seen_q) begin
					top_state_d = TOP_COMMIT;
				end
			end
			TOP_COMMIT: begin
				if (!line_full || out_free) begin
					commit      = 1'b1;
					top_state_d = TOP_IDLE;
				end
			end
			default: top_state_d = TOP_IDLE;
		endcase
	end

	// Completion flags, fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_seen_q   <= 1'b0;
			mg_seen_q   <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				ph_seen_q <= 1'b0;
				mg_seen_q <= 1'b0;
			end else begin
				if (ph_done) begin
					ph_seen_q <= 1'b1;
				end
				if (mg_done) begin
					mg_seen_q <= 1'b1;
				end
			end
			if (commit && !line_full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (commit && line_full) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sample line: cell 0 holds the oldest entry, new entries enter at the far end.
	assign new_entry.phase     = ph_value;
	assign new_entry.magnitude = mg_value;

	for (genvar j = 0; j < DELAY; j++) begin : g_line
		if (j == DELAY - 1) begin : g_tail
			assign cell_in[j] = new_entry;
		end else begin : g_body
			assign cell_in[j] = cell_out[j + 1];
		end
		pfd_line_cell u_cell (
			.clk   (clk),
			.shift (commit),
			.d     (cell_in[j]),
			.q     (cell_out[j])
		);
	end

	// The following phase is the second entry, or the new one for a single-entry line.
	if (DELAY == 1) begin : g_next_new
		assign next_phase = new_entry.phase;
	end else begin : g_next_line
		assign next_phase = cell_out[1].phase;
	end

	// Output register: phase step and magnitude of the oldest sample.
	always_ff @(posedge clk) begin
		if (commit && line_full) begin
			freq_q <= next_phase - cell_out[0].phase;
			mag_q  <= cell_out[0].magnitude;
		end
	end

	assign out_valid       = out_valid_q;
	assign freq_value      = freq_q;
	assign magnitude_value = mag_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DELAY))
		else $error("fill count exceeds line length");

	a_done_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_done || mg_done) |-> top_state_q == TOP_WORK)
		else $error("unit completion outside of the work phase");

	a_out_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> line_full)
		else $error("result presented before the line filled");

	a_commit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(top_state_q == TOP_COMMIT) |-> (ph_seen_q && mg_seen_q))
		else $error("commit without both unit results");
`endif

endmodule
